FILE: rtl/arq_window_sender_unit_macros.svh
// Assertion helpers for the checker file.
`ifndef ARQ_WINDOW_SENDER_UNIT_MACROS_SVH
`define ARQ_WINDOW_SENDER_UNIT_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define ARQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that also runs through reset.
`define ARQ_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/arq_ws_pkg.sv
package arq_ws_pkg;

    localparam int IDX_W = 16;
    localparam int ACK_W = 17;
    localparam int WIN_W = 5;
    localparam int REP_W = 2;

    localparam int unsigned MAX_WINDOW   = 20;
    localparam int unsigned START_WINDOW = 10;
    localparam int unsigned MAX_REPEATS  = 3;

    localparam logic [1:0] CMD_START   = 2'd0;
    localparam logic [1:0] CMD_REPLY   = 2'd1;
    localparam logic [1:0] CMD_TIMEOUT = 2'd2;

    localparam logic signed [ACK_W-1:0] NEG_ONE = '1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BATCH,
        PH_DRAIN,
        PH_TAIL
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_WIN,
        ST_ADV,
        ST_TAIL,
        ST_BSET,
        ST_SINGLE,
        ST_BURST
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic eval;
        logic win;
        logic adv;
        logic tail;
        logic bset;
        logic load_sgl;
        logic load_brst;
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic ev_close;
        logic ev_tail;
        logic sgl_pend;
        logic brst_pend;
        logic brst_last;
        logic out_free;
    } t_sts;

endpackage

FILE: rtl/arq_ws_ifs.sv
interface arq_ws_in_if;
    import arq_ws_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [1:0]              cmd;
    logic                    ack_ok;
    logic signed [ACK_W-1:0] ack_num;

    modport source (output valid, output cmd, output ack_ok, output ack_num, input ready);
    modport sink   (input valid, input cmd, input ack_ok, input ack_num, output ready);
endinterface

interface arq_ws_out_if;
    import arq_ws_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] send_index;
    logic             final_packet;
    logic             last_of_run;
    logic             done_res;

    modport source (output valid, output send_index, output final_packet,
                    output last_of_run, output done_res, input ready);
    modport sink   (input valid, input send_index, input final_packet,
                    input last_of_run, input done_res, output ready);
endinterface

FILE: rtl/arq_ws_ctrl.sv
module arq_ws_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  arq_ws_pkg::t_sts i_sts,
    output arq_ws_pkg::t_ctl o_ctl
);
    import arq_ws_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (i_sts.ev_close)     n_state = ST_WIN;
                else if (i_sts.ev_tail) n_state = ST_TAIL;
                else                    n_state = ST_BSET;
            end
            ST_WIN:  n_state = ST_ADV;
            ST_ADV:  n_state = ST_BSET;
            ST_TAIL: n_state = ST_BSET;
            ST_BSET: begin
                if (i_sts.sgl_pend)       n_state = ST_SINGLE;
                else if (i_sts.brst_pend) n_state = ST_BURST;
                else                      n_state = ST_IDLE;
            end
            ST_SINGLE: begin
                if (i_sts.out_free) n_state = i_sts.brst_pend ? ST_BURST : ST_IDLE;
            end
            ST_BURST: begin
                if (i_sts.out_free && i_sts.brst_last) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_ctl      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_ctl.capture = i_in_valid;
            end
            ST_EVAL:   o_ctl.eval      = 1'b1;
            ST_WIN:    o_ctl.win       = 1'b1;
            ST_ADV:    o_ctl.adv       = 1'b1;
            ST_TAIL:   o_ctl.tail      = 1'b1;
            ST_BSET:   o_ctl.bset      = 1'b1;
            ST_SINGLE: o_ctl.load_sgl  = i_sts.out_free;
            ST_BURST:  o_ctl.load_brst = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

FILE: rtl/arq_ws_dp.sv
module arq_ws_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wr_en,
    input  logic [arq_ws_pkg::IDX_W-1:0]        i_cfg_wr_data,
    input  logic [1:0]                          i_cmd,
    input  logic                                i_ack_ok,
    input  logic signed [arq_ws_pkg::ACK_W-1:0] i_ack_num,
    input  arq_ws_pkg::t_ctl                    i_ctl,
    output arq_ws_pkg::t_sts                    o_sts,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [arq_ws_pkg::IDX_W-1:0]        o_send_index,
    output logic                                o_final_packet,
    output logic                                o_last_of_run,
    output logic                                o_done_res
);
    import arq_ws_pkg::*;

    // configuration
    logic [IDX_W-1:0] r_pkt_cnt;

    // captured beat
    logic [1:0]              r_cmd;
    logic                    r_ok;
    logic signed [ACK_W-1:0] r_ack;

    // transfer bookkeeping
    logic signed [ACK_W-1:0] r_acked,   n_acked;
    logic signed [ACK_W-1:0] r_sent,    n_sent;
    logic [WIN_W-1:0]        r_window,  n_window;
    logic signed [ACK_W-1:0] r_rep_idx, n_rep_idx;
    logic [REP_W-1:0]        r_rep_cnt, n_rep_cnt;
    logic [ACK_W-1:0]        r_fresh,   n_fresh;
    logic [WIN_W-1:0]        r_replies, n_replies;
    t_phase                  r_phase,   n_phase;

    // pending results
    logic             r_sgl_pend,  n_sgl_pend;
    logic             r_brst_pend, n_brst_pend;
    logic             r_sgl_done,  n_sgl_done;
    logic [IDX_W-1:0] r_sgl_idx,   n_sgl_idx;
    logic [IDX_W-1:0] r_cur,       n_cur;
    logic [IDX_W-1:0] r_last,      n_last;

    // output register
    logic             r_o_valid;
    logic [IDX_W-1:0] r_o_idx;
    logic             r_o_final;
    logic             r_o_last;
    logic             r_o_done;

    logic signed [ACK_W-1:0] nm1;
    logic signed [ACK_W:0]   nm1_x;
    logic signed [ACK_W-1:0] ack_cl;
    logic signed [ACK_W-1:0] acked_p1;
    logic                    acked_lt;
    logic                    dup;
    logic                    newer;
    logic [WIN_W-1:0]        replies_inc;
    logic signed [ACK_W:0]   ack_diff;
    logic [ACK_W:0]          fresh_sum;
    logic [WIN_W:0]          win_p1;
    logic [WIN_W:0]          step;
    logic signed [ACK_W:0]   sent_x;
    logic signed [ACK_W:0]   adv_x;
    logic                    adv_lt;
    logic signed [ACK_W:0]   first_x;
    logic signed [ACK_W:0]   lastc_x;
    logic signed [ACK_W:0]   last_x;
    logic                    sgl_final;
    logic                    cur_final;

    assign nm1   = $signed({1'b0, r_pkt_cnt}) - $signed(ACK_W'(1));
    assign nm1_x = {nm1[ACK_W-1], nm1};

    // ack number clamped to -1..N-1 on capture
    always_comb begin
        ack_cl = i_ack_num;
        if (i_ack_num < NEG_ONE) ack_cl = NEG_ONE;
        else if (i_ack_num > nm1) ack_cl = nm1;
    end

    assign acked_p1    = r_acked + $signed(ACK_W'(1));
    assign acked_lt    = r_acked < nm1;
    assign dup         = r_ok && (r_ack == r_acked) &&
                         ((r_ack != r_rep_idx) || (r_rep_cnt < REP_W'(MAX_REPEATS)));
    assign newer       = r_ok && (r_ack > r_acked);
    assign replies_inc = r_replies + WIN_W'(1);
    assign ack_diff    = {r_ack[ACK_W-1], r_ack} - {r_acked[ACK_W-1], r_acked};
    assign fresh_sum   = {1'b0, r_fresh} + unsigned'(ack_diff);

    // send mark advances by the window plus one per batch, at most half the maximum window
    assign win_p1  = {1'b0, r_window} + (WIN_W+1)'(1);
    assign step    = (win_p1 < (WIN_W+1)'(MAX_WINDOW / 2)) ? win_p1
                                                           : (WIN_W+1)'(MAX_WINDOW / 2);
    assign sent_x  = {r_sent[ACK_W-1], r_sent};
    assign adv_x   = sent_x + $signed({{(ACK_W-WIN_W){1'b0}}, step});
    assign adv_lt  = adv_x < nm1_x;
    assign first_x = sent_x + $signed((ACK_W+1)'(1));
    assign lastc_x = first_x + $signed({{(ACK_W+1-WIN_W){1'b0}}, r_window});
    assign last_x  = (lastc_x < nm1_x) ? lastc_x : nm1_x;

    assign sgl_final = !r_sgl_done && ($signed({1'b0, r_sgl_idx}) == nm1);
    assign cur_final = $signed({1'b0, r_cur}) == nm1;

    always_comb begin
        o_sts.ev_close  = 1'b0;
        o_sts.ev_tail   = 1'b0;
        if (r_phase == PH_BATCH) begin
            if (r_cmd == CMD_TIMEOUT) begin
                o_sts.ev_close = 1'b1;
            end else if (r_cmd == CMD_REPLY) begin
                o_sts.ev_close = (dup && !acked_lt) || (replies_inc >= r_window);
            end
        end else if (r_phase == PH_DRAIN) begin
            o_sts.ev_tail = r_cmd == CMD_TIMEOUT;
        end else if (r_phase == PH_TAIL) begin
            o_sts.ev_tail = (r_cmd == CMD_REPLY) || (r_cmd == CMD_TIMEOUT);
        end
        o_sts.sgl_pend  = r_sgl_pend;
        o_sts.brst_pend = r_brst_pend;
        o_sts.brst_last = r_cur == r_last;
        o_sts.out_free  = !r_o_valid || i_out_ready;
    end

    always_comb begin
        n_acked     = r_acked;
        n_sent      = r_sent;
        n_window    = r_window;
        n_rep_idx   = r_rep_idx;
        n_rep_cnt   = r_rep_cnt;
        n_fresh     = r_fresh;
        n_replies   = r_replies;
        n_phase     = r_phase;
        n_sgl_pend  = r_sgl_pend;
        n_brst_pend = r_brst_pend;
        n_sgl_done  = r_sgl_done;
        n_sgl_idx   = r_sgl_idx;
        n_cur       = r_cur;
        n_last      = r_last;

        if (i_ctl.eval) begin
            n_sgl_pend  = 1'b0;
            n_brst_pend = 1'b0;
            n_sgl_done  = 1'b0;
            case (r_cmd)
                CMD_START: begin
                    n_acked   = NEG_ONE;
                    n_sent    = NEG_ONE;
                    n_window  = WIN_W'(START_WINDOW);
                    n_rep_idx = NEG_ONE;
                    n_rep_cnt = '0;
                    n_fresh   = '0;
                    n_replies = '0;
                    if (r_pkt_cnt == '0) begin
                        n_phase    = PH_IDLE;
                        n_sgl_pend = 1'b1;
                        n_sgl_done = 1'b1;
                    end else begin
                        n_phase     = PH_BATCH;
                        n_brst_pend = 1'b1;
                    end
                end
                CMD_TIMEOUT: begin
                    if (r_phase == PH_BATCH && acked_lt) begin
                        n_rep_idx  = acked_p1;
                        n_sgl_pend = 1'b1;
                        n_sgl_idx  = acked_p1[IDX_W-1:0];
                    end
                end
                CMD_REPLY: begin
                    if (r_phase == PH_BATCH) begin
                        n_replies = replies_inc;
                        if (dup) begin
                            if (r_ack == r_rep_idx) begin
                                n_rep_cnt = r_rep_cnt + REP_W'(1);
                            end else begin
                                n_rep_cnt = '0;
                                n_rep_idx = r_ack;
                            end
                            if (acked_lt) begin
                                n_sgl_pend = 1'b1;
                                n_sgl_idx  = acked_p1[IDX_W-1:0];
                            end
                        end else if (newer) begin
                            n_fresh = fresh_sum[ACK_W-1:0];
                            n_acked = r_ack;
                        end
                    end else if (r_phase == PH_TAIL && newer) begin
                        n_acked = r_ack;
                    end
                end
                default: ;
            endcase
        end else if (i_ctl.tail) begin
            n_sgl_pend = 1'b1;
            if (acked_lt) begin
                n_phase    = PH_TAIL;
                n_sgl_done = 1'b0;
                n_sgl_idx  = acked_p1[IDX_W-1:0];
            end else begin
                n_phase    = PH_IDLE;
                n_sgl_done = 1'b1;
            end
        end else if (i_ctl.win) begin
            if (r_fresh == '0) begin
                n_window = WIN_W'(1);
            end else if (r_fresh > ACK_W'(MAX_WINDOW)) begin
                n_window = WIN_W'(MAX_WINDOW);
            end else begin
                n_window = r_fresh[WIN_W-1:0];
            end
        end else if (i_ctl.adv) begin
            if (adv_lt) begin
                n_sent      = adv_x[ACK_W-1:0];
                n_brst_pend = 1'b1;
                n_fresh     = '0;
                n_replies   = '0;
            end else begin
                n_sent  = nm1;
                n_phase = PH_DRAIN;
            end
        end else if (i_ctl.bset) begin
            n_cur  = first_x[IDX_W-1:0];
            n_last = last_x[IDX_W-1:0];
        end else if (i_ctl.load_brst) begin
            n_cur = r_cur + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_cnt   <= IDX_W'(1);
            r_acked     <= NEG_ONE;
            r_sent      <= NEG_ONE;
            r_window    <= WIN_W'(START_WINDOW);
            r_rep_idx   <= NEG_ONE;
            r_rep_cnt   <= '0;
            r_fresh     <= '0;
            r_replies   <= '0;
            r_phase     <= PH_IDLE;
            r_sgl_pend  <= 1'b0;
            r_brst_pend <= 1'b0;
            r_sgl_done  <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_pkt_cnt <= i_cfg_wr_data;
            r_acked     <= n_acked;
            r_sent      <= n_sent;
            r_window    <= n_window;
            r_rep_idx   <= n_rep_idx;
            r_rep_cnt   <= n_rep_cnt;
            r_fresh     <= n_fresh;
            r_replies   <= n_replies;
            r_phase     <= n_phase;
            r_sgl_pend  <= n_sgl_pend;
            r_brst_pend <= n_brst_pend;
            r_sgl_done  <= n_sgl_done;
            if (i_ctl.load_sgl || i_ctl.load_brst) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sgl_idx <= n_sgl_idx;
        r_cur     <= n_cur;
        r_last    <= n_last;
        if (i_ctl.capture) begin
            r_cmd <= i_cmd;
            r_ok  <= i_ack_ok;
            r_ack <= ack_cl;
        end
        if (i_ctl.load_sgl) begin
            r_o_idx   <= r_sgl_done ? '0 : r_sgl_idx;
            r_o_final <= sgl_final;
            r_o_last  <= !r_brst_pend;
            r_o_done  <= r_sgl_done;
        end else if (i_ctl.load_brst) begin
            r_o_idx   <= r_cur;
            r_o_final <= cur_final;
            r_o_last  <= r_cur == r_last;
            r_o_done  <= 1'b0;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_send_index   = r_o_idx;
    assign o_final_packet = r_o_final;
    assign o_last_of_run  = r_o_last;
    assign o_done_res     = r_o_done;

endmodule

FILE: rtl/arq_window_sender_unit.sv
// Sender-side bookkeeping for a windowed, acknowledged packet transfer.
// Input channel i_in: one beat per event (cmd = start / reply / timeout,
// ack_ok, ack_num). Output channel o_out: one beat per packet index to send,
// or a single done beat; last_of_run marks the final beat caused by an event.
// i_cfg_wr_en / i_cfg_wr_data set the packet count; write only while idle.
// One event is worked at a time. After acceptance the controller steps through
// evaluation; then window resize and send-mark advance when a batch closes, or
// a tail step; then burst range setup. The results are then registered one per
// cycle through the output register while the receiver does not stall.
// i_in.ready rises again once the last result sits in the output register,
// so the next event may be taken while that beat waits.
// If the receiver stalls, the output register holds its beat and the burst
// pauses. Reset (synchronous, active low) clears the bookkeeping to idle,
// sets the packet count to one and drops o_out.valid.
module arq_window_sender_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [arq_ws_pkg::IDX_W-1:0] i_cfg_wr_data,
    arq_ws_in_if.sink                    i_in,
    arq_ws_out_if.source                 o_out
);
    import arq_ws_pkg::*;

    t_ctl ctl;
    t_sts sts;

    arq_ws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    arq_ws_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_cmd          (i_in.cmd),
        .i_ack_ok       (i_in.ack_ok),
        .i_ack_num      (i_in.ack_num),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_send_index   (o_out.send_index),
        .o_final_packet (o_out.final_packet),
        .o_last_of_run  (o_out.last_of_run),
        .o_done_res     (o_out.done_res)
    );

endmodule

FILE: rtl/arq_ws_checker.sv
`include "arq_window_sender_unit_macros.svh"

module arq_ws_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [arq_ws_pkg::IDX_W-1:0] i_send_index,
    input logic                         i_final_packet,
    input logic                         i_last_of_run,
    input logic                         i_done_res
);

    `ARQ_ASSERT_NR(a_rst_drops_valid, i_clk, !i_rst_n |=> !i_out_valid, "output valid after reset")

    // a done beat carries no send and always ends its run
    `ARQ_ASSERT(a_done_form, i_clk, i_rst_n, (i_out_valid && i_done_res) |-> ((i_send_index == '0) && !i_final_packet && i_last_of_run), "malformed done beat")

    // more results of the current event still to come: no new event taken
    `ARQ_ASSERT(a_run_blocks_in, i_clk, i_rst_n, (i_out_valid && !i_last_of_run) |-> !i_in_ready, "input taken mid-run")

    `ARQ_ASSERT(a_stall_holds, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_send_index)), "stalled beat changed")

endmodule

bind arq_window_sender_unit arq_ws_checker u_arq_ws_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_send_index   (o_out.send_index),
    .i_final_packet (o_out.final_packet),
    .i_last_of_run  (o_out.last_of_run),
    .i_done_res     (o_out.done_res)
);
